@@ sv/rtp_audio_level_extension_parser_macros.svh @@
// Assertion macros for the RTP audio-level extension parser.
// No dependencies. Bodies are empty when SYNTHESIS is defined.
`ifndef RTP_AUDIO_LEVEL_EXTENSION_PARSER_MACROS_SVH
`define RTP_AUDIO_LEVEL_EXTENSION_PARSER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled during reset.
`define RTPAL_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rtpal assertion failed");

// Next-cycle implication, disabled during reset.
`define RTPAL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rtpal assertion failed");

`else

`define RTPAL_ASSERT_NOW(label, clk, rst, ante, cons)
`define RTPAL_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

@@ sv/rtpal_pkg.sv @@
// Shared constants for the RTP audio-level extension parser.
// No dependencies.
package rtpal_pkg;

   localparam int unsigned MAX_PACKET_BYTES = 65535;

   localparam logic [15:0] BEDE_PROFILE = 16'hBEDE;
   localparam logic [3:0]  STOP_ID      = 4'd15;
   localparam logic [3:0]  PAD_ID       = 4'd0;
   localparam logic [3:0]  LEVEL_ID_RST = 4'd1;

   // Register indexes on the CSR port
   localparam logic REG_LEVEL_EXT_ID = 1'b0;

   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;

endpackage

@@ sv/rtp_audio_level_extension_parser.sv @@
// RTP one-byte header extension parser that extracts the audio level.
// Depends on rtpal_pkg and rtp_audio_level_extension_parser_macros.svh.
//
//   channel | ports                          | direction | moves
//   --------+--------------------------------+-----------+---------------------------
//   req     | req_valid/req_ready            | in        | one packet byte per request
//   rsp     | rsp_valid/rsp_ready            | out       | one result per packet
//   csr     | csr_psel/penable/pwrite/paddr  | in/out    | level_ext_id register
//
// Throughput is one byte per cycle while no final byte is held; a request is
// registered in the input register and its result (final byte only) is then
// loaded from there into the result register, which drives rsp_valid.
// Reset is synchronous; the register file resets to ID 1.
// A final byte holds in the input register while an earlier result is still
// unclaimed; all other bytes advance regardless of rsp_ready.
`include "rtp_audio_level_extension_parser_macros.svh"

module rtp_audio_level_extension_parser #(
   parameter int unsigned MAX_PACKET_BYTES = rtpal_pkg::MAX_PACKET_BYTES
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [7:0]                          req_data_byte,
   input  logic                                req_last_byte,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_status,
   output logic [6:0]                          rsp_level_dbov,
   output logic                                rsp_level_updated,
   // CSR port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [rtpal_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [rtpal_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [rtpal_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                                csr_pready
);

   // Walk phase codes
   localparam logic [2:0] PH_HEADER    = 3'd0;
   localparam logic [2:0] PH_CSRC      = 3'd1;
   localparam logic [2:0] PH_EXTHDR    = 3'd2;
   localparam logic [2:0] PH_ELEM_ID   = 3'd3;
   localparam logic [2:0] PH_ELEM_DATA = 3'd4;
   localparam logic [2:0] PH_DONE      = 3'd5;

   localparam logic [15:0] MaxPos = 16'(MAX_PACKET_BYTES);

   // ------------------------------------------------------------------
   // CSR: one register, written in the APB access phase
   // ------------------------------------------------------------------
   logic [3:0] level_ext_id_ff, level_ext_id_in;
   logic       csr_wr;
   logic       csr_reg_sel;

   assign csr_pready  = 1'b1;
   assign csr_reg_sel = (csr_paddr[2] == rtpal_pkg::REG_LEVEL_EXT_ID);
   assign csr_wr      = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      level_ext_id_in = level_ext_id_ff;
      if (csr_wr && csr_reg_sel) begin
         level_ext_id_in = csr_pwdata[3:0];
      end
   end

   assign csr_prdata = csr_reg_sel ?
                       {{(rtpal_pkg::CSR_DATA_W-4){1'b0}}, level_ext_id_ff} :
                       '0;

   // ------------------------------------------------------------------
   // Input register
   // ------------------------------------------------------------------
   logic       s1_valid_ff, s1_valid_in;
   logic [7:0] s1_byte_ff, s1_byte_in;
   logic       s1_last_ff, s1_last_in;
   logic       s1_adv;
   logic       rsp_valid_ff, rsp_valid_in;

   // A final byte needs a free result register; any other byte just advances.
   assign s1_adv    = s1_valid_ff & (~s1_last_ff | ~rsp_valid_ff | rsp_ready);
   assign req_ready = ~s1_valid_ff | s1_adv;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_byte_in  = s1_byte_ff;
      s1_last_in  = s1_last_ff;
      if (req_valid && req_ready) begin
         s1_valid_in = 1'b1;
         s1_byte_in  = req_data_byte;
         s1_last_in  = req_last_byte;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
   end

   // ------------------------------------------------------------------
   // Packet state
   // ------------------------------------------------------------------
   logic [15:0] pos_ff, pos_in;
   logic [3:0]  csrc_ff, csrc_in;
   logic        has_ext_ff, has_ext_in;
   logic [15:0] profile_ff, profile_in;
   logic [15:0] ext_words_ff, ext_words_in;
   logic [2:0]  phase_ff, phase_in;
   logic [4:0]  left_ff, left_in;
   logic        match_ff, match_in;
   logic [6:0]  cand_ff, cand_in;
   logic        cand_valid_ff, cand_valid_in;
   logic [6:0]  committed_ff, committed_in;

   // Result register payload
   logic        rsp_status_ff, rsp_status_in;
   logic [6:0]  rsp_level_ff, rsp_level_in;
   logic        rsp_upd_ff, rsp_upd_in;

   // Boundaries of the current packet
   logic [6:0]  csrc_end;
   logic [18:0] area_end;
   logic [18:0] area_rem;
   logic [3:0]  elem_id;
   logic [3:0]  elem_len;
   logic        take;

   // Values after this byte, before end-of-packet clearing
   logic [15:0] pos_w;
   logic [3:0]  csrc_w;
   logic        has_ext_w;
   logic [15:0] profile_w;
   logic [15:0] ext_words_w;
   logic [2:0]  phase_w;
   logic [4:0]  left_w;
   logic        match_w;
   logic [6:0]  cand_w;
   logic        cand_valid_w;
   logic [6:0]  csrc_end_w;
   logic [18:0] need_w;
   logic        status_w;

   assign csrc_end = 7'd12 + {1'b0, csrc_ff, 2'b00};
   assign area_end = {12'd0, csrc_end} + 19'd4 + {1'b0, ext_words_ff, 2'b00};
   assign area_rem = area_end - {3'd0, pos_ff} - 19'd1;
   assign elem_id  = s1_byte_ff[7:4];
   assign elem_len = s1_byte_ff[3:0];
   assign take     = s1_adv & (pos_ff < MaxPos);

   // Walk one byte
   always_comb begin
      pos_w        = pos_ff;
      csrc_w       = csrc_ff;
      has_ext_w    = has_ext_ff;
      profile_w    = profile_ff;
      ext_words_w  = ext_words_ff;
      phase_w      = phase_ff;
      left_w       = left_ff;
      match_w      = match_ff;
      cand_w       = cand_ff;
      cand_valid_w = cand_valid_ff;
      if (take) begin
         pos_w = pos_ff + 16'd1;
         unique case (phase_ff)
            PH_HEADER: begin
               if (pos_ff == 16'd0) begin
                  csrc_w    = s1_byte_ff[3:0];
                  has_ext_w = s1_byte_ff[4];
               end
               if (pos_ff == 16'd11) begin
                  if (csrc_ff != 4'd0) begin
                     phase_w = PH_CSRC;
                  end else begin
                     phase_w = has_ext_ff ? PH_EXTHDR : PH_DONE;
                  end
               end
            end
            PH_CSRC: begin
               if (({1'b0, pos_ff} + 17'd1) >= {10'd0, csrc_end}) begin
                  phase_w = has_ext_ff ? PH_EXTHDR : PH_DONE;
               end
            end
            PH_EXTHDR: begin
               // csrc_end is word aligned, so the offset is the low two bits
               unique case (pos_ff[1:0])
                  2'd0: profile_w = {s1_byte_ff, 8'd0};
                  2'd1: profile_w = {profile_ff[15:8], s1_byte_ff};
                  2'd2: ext_words_w = {s1_byte_ff, 8'd0};
                  default: begin
                     ext_words_w = {ext_words_ff[15:8], s1_byte_ff};
                     phase_w = (profile_ff == rtpal_pkg::BEDE_PROFILE) ?
                               PH_ELEM_ID : PH_DONE;
                  end
               endcase
            end
            PH_ELEM_ID: begin
               priority if ({3'd0, pos_ff} >= area_end) begin
                  phase_w = PH_DONE;
               end else if (elem_id == rtpal_pkg::PAD_ID) begin
                  phase_w = PH_ELEM_ID;
               end else if (elem_id == rtpal_pkg::STOP_ID ||
                            area_rem < {14'd0, {1'b0, elem_len} + 5'd1}) begin
                  phase_w = PH_DONE;
               end else begin
                  match_w = (elem_id == level_ext_id_ff);
                  if (match_w && elem_len != 4'd0) begin
                     phase_w = PH_DONE;
                  end else begin
                     left_w  = {1'b0, elem_len} + 5'd1;
                     phase_w = PH_ELEM_DATA;
                  end
               end
            end
            PH_ELEM_DATA: begin
               if (match_ff) begin
                  cand_w       = s1_byte_ff[6:0];
                  cand_valid_w = 1'b1;
               end
               left_w = left_ff - 5'd1;
               if (left_w == 5'd0) begin
                  phase_w = PH_ELEM_ID;
               end
            end
            default: begin
               phase_w = phase_ff;
            end
         endcase
      end
   end

   // Length check against the header plus extension
   assign csrc_end_w = 7'd12 + {1'b0, csrc_w, 2'b00};
   assign need_w     = has_ext_w ?
                       ({12'd0, csrc_end_w} + 19'd4 + {1'b0, ext_words_w, 2'b00}) :
                       {12'd0, csrc_end_w};
   assign status_w   = ({3'd0, pos_w} < need_w);

   // Commit on the final byte, then clear the packet state
   always_comb begin
      pos_in        = pos_w;
      csrc_in       = csrc_w;
      has_ext_in    = has_ext_w;
      profile_in    = profile_w;
      ext_words_in  = ext_words_w;
      phase_in      = phase_w;
      left_in       = left_w;
      match_in      = match_w;
      cand_in       = cand_w;
      cand_valid_in = cand_valid_w;
      committed_in  = committed_ff;
      rsp_status_in = rsp_status_ff;
      rsp_level_in  = rsp_level_ff;
      rsp_upd_in    = rsp_upd_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;
      if (s1_adv && s1_last_ff) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = status_w;
         rsp_upd_in    = ~status_w & cand_valid_w;
         if (!status_w && cand_valid_w) begin
            committed_in = cand_w;
         end
         rsp_level_in  = committed_in;
         pos_in        = '0;
         csrc_in       = '0;
         has_ext_in    = 1'b0;
         profile_in    = '0;
         ext_words_in  = '0;
         phase_in      = PH_HEADER;
         left_in       = '0;
         match_in      = 1'b0;
         cand_in       = '0;
         cand_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ext_id_ff <= rtpal_pkg::LEVEL_ID_RST;
         s1_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         pos_ff          <= '0;
         csrc_ff         <= '0;
         has_ext_ff      <= 1'b0;
         profile_ff      <= '0;
         ext_words_ff    <= '0;
         phase_ff        <= PH_HEADER;
         left_ff         <= '0;
         match_ff        <= 1'b0;
         cand_ff         <= '0;
         cand_valid_ff   <= 1'b0;
         committed_ff    <= '0;
      end else begin
         level_ext_id_ff <= level_ext_id_in;
         s1_valid_ff     <= s1_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
         pos_ff          <= pos_in;
         csrc_ff         <= csrc_in;
         has_ext_ff      <= has_ext_in;
         profile_ff      <= profile_in;
         ext_words_ff    <= ext_words_in;
         phase_ff        <= phase_in;
         left_ff         <= left_in;
         match_ff        <= match_in;
         cand_ff         <= cand_in;
         cand_valid_ff   <= cand_valid_in;
         committed_ff    <= committed_in;
      end
   end

   // Payload registers: no reset needed
   always_ff @(posedge clock) begin
      s1_byte_ff    <= s1_byte_in;
      s1_last_ff    <= s1_last_in;
      rsp_status_ff <= rsp_status_in;
      rsp_level_ff  <= rsp_level_in;
      rsp_upd_ff    <= rsp_upd_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_level_dbov    = rsp_level_ff;
   assign rsp_level_updated = rsp_upd_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   `RTPAL_ASSERT_NEXT(a_last_gives_rsp, clock, reset, s1_adv && s1_last_ff, rsp_valid_ff)
   `RTPAL_ASSERT_NEXT(a_last_clears_walk, clock, reset, s1_adv && s1_last_ff,
                      pos_ff == 16'd0 && phase_ff == PH_HEADER && !cand_valid_ff)
   `RTPAL_ASSERT_NOW(a_upd_only_ok, clock, reset, rsp_valid_ff, !(rsp_status_ff && rsp_upd_ff))
   `RTPAL_ASSERT_NOW(a_walk_needs_bede, clock, reset,
                     phase_ff == PH_ELEM_ID || phase_ff == PH_ELEM_DATA,
                     has_ext_ff && profile_ff == rtpal_pkg::BEDE_PROFILE)
   `RTPAL_ASSERT_NOW(a_stall_cause, clock, reset, !req_ready,
                     s1_valid_ff && s1_last_ff && rsp_valid_ff && !rsp_ready)

endmodule

@@ bench/tb_rtp_audio_level_extension_parser.sv @@
// Self-checking testbench for rtp_audio_level_extension_parser.
// Depends on rtpal_pkg and the parser RTL. Builds RTP packets byte by byte, predicts
// the per-packet audio-level result and checks every response against it.
`timescale 1ns / 1ps

module tb_rtp_audio_level_extension_parser;

   // Hard stop for the whole run; the slowest legal run is far below this.
   localparam longint RUN_LIMIT_NS = 64'd2_000_000;
   // Cycles to let the pipeline settle once the last result is in.
   localparam int SETTLE_CYCLES = 4;
   localparam logic [rtpal_pkg::CSR_ADDR_W-1:0] LEVEL_ID_ADDR =
      {rtpal_pkg::REG_LEVEL_EXT_ID, 2'b00};

   // Where the walk through the packet stands.
   typedef enum logic [2:0] {
      WALK_HEADER,
      WALK_CSRC,
      WALK_EXT_HDR,
      WALK_ELEM_ID,
      WALK_ELEM_DATA,
      WALK_DONE
   } walk_phase_type;

   typedef struct packed {
      logic       status;
      logic [6:0] level_dbov;
      logic       level_updated;
   } level_report_type;

   // DUT ports; every input starts at a known value.
   logic                             clock;
   logic                             reset             = 1'b1;
   logic                             req_valid         = 1'b0;
   logic                             req_ready;
   logic [7:0]                       req_data_byte     = 8'h00;
   logic                             req_last_byte     = 1'b0;
   logic                             rsp_valid;
   logic                             rsp_ready         = 1'b0;
   logic                             rsp_status;
   logic [6:0]                       rsp_level_dbov;
   logic                             rsp_level_updated;
   logic                             csr_psel          = 1'b0;
   logic                             csr_penable       = 1'b0;
   logic                             csr_pwrite        = 1'b0;
   logic [rtpal_pkg::CSR_ADDR_W-1:0] csr_paddr         = '0;
   logic [rtpal_pkg::CSR_DATA_W-1:0] csr_pwdata        = '0;
   logic [rtpal_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                             csr_pready;

   // Handshake shaping: percent of cycles each side idles, plus a long receiver hold.
   int tx_idle_pct     = 0;
   int rx_idle_pct     = 0;
   int rx_hold_request = 0;
   int rx_hold_left    = 0;

   // Bookkeeping for the summary and the verdict.
   int error_count    = 0;
   int bytes_accepted = 0;
   int packets_sent   = 0;
   int results_seen   = 0;
   int updates_seen   = 0;
   int shorts_seen    = 0;

   // Packet under construction, and results still owed by the DUT.
   logic [7:0]       pkt_q[$];
   level_report_type level_reports_q[$];

   // Parser mirror: configuration, per-packet walk state and the stored level.
   logic [3:0]     level_id = rtpal_pkg::LEVEL_ID_RST;
   logic [15:0]    at_pos;
   logic [3:0]     hdr_csrc;
   logic           hdr_ext;
   logic [15:0]    ext_profile;
   logic [15:0]    ext_len_words;
   walk_phase_type walk;
   logic [4:0]     elem_left;
   logic           elem_hit;
   logic [6:0]     cand_level;
   logic           cand_valid;
   logic [6:0]     stored_level = 7'd0;

   rtp_audio_level_extension_parser DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_data_byte     (req_data_byte),
      .req_last_byte     (req_last_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_level_dbov    (rsp_level_dbov),
      .rsp_level_updated (rsp_level_updated),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------------------
   // Level predictor
   // ---------------------------------------------------------------------------------

   // Drop all per-packet state; the stored level survives.
   function automatic void clear_walk();
      at_pos        = '0;
      hdr_csrc      = '0;
      hdr_ext       = 1'b0;
      ext_profile   = '0;
      ext_len_words = '0;
      walk          = WALK_HEADER;
      elem_left     = '0;
      elem_hit      = 1'b0;
      cand_level    = '0;
      cand_valid    = 1'b0;
   endfunction

   // Advance the walk by one accepted byte; on the final byte queue the result owed.
   function automatic void parse_level_byte(input logic [7:0] b, input logic fin);
      int unsigned      p;
      int unsigned      csrc_end;
      int unsigned      area_end;
      int unsigned      need;
      int unsigned      len;
      logic [3:0]       id;
      level_report_type rep;
      p        = at_pos;
      csrc_end = 12 + 4 * hdr_csrc;
      area_end = csrc_end + 4 + 4 * ext_len_words;
      id       = b[7:4];
      len      = b[3:0];
      // Bytes past the size limit are never seen and do not count.
      if (p < rtpal_pkg::MAX_PACKET_BYTES) begin
         case (walk)
            WALK_HEADER: begin
               if (p == 0) begin
                  hdr_csrc = b[3:0];
                  hdr_ext  = b[4];
               end
               if (p == 11) begin
                  if (hdr_csrc != 0) walk = WALK_CSRC;
                  else walk = hdr_ext ? WALK_EXT_HDR : WALK_DONE;
               end
            end
            WALK_CSRC: begin
               if (p + 1 >= csrc_end) walk = hdr_ext ? WALK_EXT_HDR : WALK_DONE;
            end
            WALK_EXT_HDR: begin
               case (p - csrc_end)
                  0: ext_profile = {b, 8'h00};
                  1: ext_profile[7:0] = b;
                  2: ext_len_words = {b, 8'h00};
                  default: begin
                     ext_len_words[7:0] = b;
                     walk = (ext_profile == rtpal_pkg::BEDE_PROFILE) ? WALK_ELEM_ID
                                                                     : WALK_DONE;
                  end
               endcase
            end
            WALK_ELEM_ID: begin
               // Past the area, stop; padding is a single skipped byte.
               if (p >= area_end) walk = WALK_DONE;
               else if (id != rtpal_pkg::PAD_ID) begin
                  if (id == rtpal_pkg::STOP_ID || area_end - p - 1 < len + 1)
                     walk = WALK_DONE;
                  else begin
                     elem_hit = (id == level_id);
                     // A level element must carry exactly one data byte.
                     if (elem_hit && len != 0) walk = WALK_DONE;
                     else begin
                        elem_left = 5'(len + 1);
                        walk      = WALK_ELEM_DATA;
                     end
                  end
               end
            end
            WALK_ELEM_DATA: begin
               if (elem_hit) begin
                  cand_level = b[6:0];
                  cand_valid = 1'b1;
               end
               elem_left = elem_left - 5'd1;
               if (elem_left == 0) walk = WALK_ELEM_ID;
            end
            default: ;
         endcase
         at_pos = at_pos + 16'd1;
      end
      if (fin) begin
         need = 12 + 4 * hdr_csrc;
         if (hdr_ext) need = need + 4 + 4 * ext_len_words;
         rep.status        = (at_pos < need);
         rep.level_updated = 1'b0;
         if (!rep.status && cand_valid) begin
            stored_level      = cand_level;
            rep.level_updated = 1'b1;
         end
         rep.level_dbov = stored_level;
         level_reports_q.push_back(rep);
         clear_walk();
      end
   endfunction

   initial clear_walk();

   // ---------------------------------------------------------------------------------
   // Monitors and checker
   // ---------------------------------------------------------------------------------

   task automatic report_mismatch(input string msg);
      error_count++;
      $display("%0t ns MISMATCH %s", $time, msg);
   endtask

   // Feed every accepted request to the predictor.
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         bytes_accepted++;
         parse_level_byte(req_data_byte, req_last_byte);
      end
   end

   // Compare each accepted result with the oldest one owed.
   always @(posedge clock) begin
      level_report_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (rsp_level_updated) updates_seen++;
         if (rsp_status) shorts_seen++;
         if (level_reports_q.size() == 0) begin
            report_mismatch($sformatf("result with nothing pending: status %0d level %0d upd %0d",
                                      rsp_status, rsp_level_dbov, rsp_level_updated));
         end else begin
            want = level_reports_q.pop_front();
            if (rsp_status !== want.status)
               report_mismatch($sformatf("status: got %0d, expected %0d",
                                         rsp_status, want.status));
            if (rsp_level_dbov !== want.level_dbov)
               report_mismatch($sformatf("level: got %0d, expected %0d",
                                         rsp_level_dbov, want.level_dbov));
            if (rsp_level_updated !== want.level_updated)
               report_mismatch($sformatf("level_updated: got %0d, expected %0d",
                                         rsp_level_updated, want.level_updated));
         end
      end
   end

   // Receiver: random idling, or a long hold when a test asks for one.
   always @(negedge clock) begin
      if (rx_hold_request != 0) begin
         rx_hold_left    = rx_hold_request;
         rx_hold_request = 0;
      end
      if (rx_hold_left != 0) begin
         rsp_ready <= 1'b0;
         rx_hold_left--;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   // ---------------------------------------------------------------------------------
   // Drivers
   // ---------------------------------------------------------------------------------

   // Offer one request after a random gap; hold it until the DUT takes it.
   task automatic send_request(input logic [7:0] data, input logic last);
      @(negedge clock);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= data;
      req_last_byte <= last;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_packet();
      for (int i = 0; i < pkt_q.size(); i++) send_request(pkt_q[i], i == pkt_q.size() - 1);
      packets_sent++;
   endtask

   // Stop offering, then hold until every owed result is in and the pipe is empty.
   task automatic wait_for_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (level_reports_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One APB transfer: setup cycle, then access until pready.
   task automatic csr_access(input logic write,
                             input logic [rtpal_pkg::CSR_DATA_W-1:0] wdata,
                             output logic [rtpal_pkg::CSR_DATA_W-1:0] rdata);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= LEVEL_ID_ADDR;
      csr_pwdata  <= wdata;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Reprogram the level ID once the DUT is idle, then read it back.
   task automatic set_level_id(input logic [3:0] id);
      logic [rtpal_pkg::CSR_DATA_W-1:0] wr;
      logic [rtpal_pkg::CSR_DATA_W-1:0] rd;
      wait_for_results();
      wr      = '0;
      wr[3:0] = id;
      csr_access(1'b1, wr, rd);
      level_id = id;
      csr_access(1'b0, '0, rd);
      if (rd !== wr)
         report_mismatch($sformatf("level_ext_id readback: got %0h, expected %0h", rd, wr));
   endtask

   // ---------------------------------------------------------------------------------
   // Packet builders
   // ---------------------------------------------------------------------------------

   // Fixed header with random filler, then the CSRC list.
   function automatic void begin_packet(input logic [3:0] csrc, input logic ext);
      logic [2:0] top;
      top = 3'($urandom_range(7));
      pkt_q.delete();
      pkt_q.push_back({top, ext, csrc});
      for (int i = 1; i < 12 + 4 * csrc; i++) pkt_q.push_back(8'($urandom_range(255)));
   endfunction

   // Append one 32-bit word, most significant byte first.
   function automatic void push_word(input logic [31:0] w);
      for (int i = 3; i >= 0; i--) pkt_q.push_back(w[8 * i +: 8]);
   endfunction

   function automatic void begin_ext_packet(input logic [3:0] csrc, input logic [15:0] profile,
                                            input logic [15:0] words);
      begin_packet(csrc, 1'b1);
      push_word({profile, words});
   endfunction

   // Mostly well-formed packets with random elements; some noise, some truncated.
   function automatic void build_random_packet();
      int         n;
      int         r;
      int         fill;
      int         len;
      int         words;
      logic       ext;
      logic [3:0] id;
      if ($urandom_range(99) < 6) begin
         pkt_q.delete();
         n = $urandom_range(1, 40);
         repeat (n) pkt_q.push_back(8'($urandom_range(255)));
      end else begin
         ext = ($urandom_range(9) != 0);
         begin_packet(($urandom_range(7) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(2)),
                      ext);
         if (ext) begin
            // An occasional huge length makes the packet short.
            words = ($urandom_range(9) == 0) ? $urandom_range(65535) : $urandom_range(4);
            push_word({(($urandom_range(9) == 0) ? 16'($urandom) : rtpal_pkg::BEDE_PROFILE),
                       16'(words)});
            fill = (4 * words < 24) ? 4 * words : 24;
            n    = 0;
            // Elements may straddle the area end; that is the overrun case.
            while (n < fill) begin
               r = $urandom_range(99);
               if (r < 15) begin
                  pkt_q.push_back(8'h00);
                  n += 1;
               end else if (r < 50) begin
                  pkt_q.push_back({level_id, 4'h0});
                  pkt_q.push_back(8'($urandom_range(255)));
                  n += 2;
               end else if (r < 85) begin
                  id  = 4'($urandom_range(1, 14));
                  len = $urandom_range(3);
                  pkt_q.push_back({id, 4'(len)});
                  repeat (len + 1) pkt_q.push_back(8'($urandom_range(255)));
                  n += len + 2;
               end else if (r < 92) begin
                  pkt_q.push_back({rtpal_pkg::STOP_ID, 4'($urandom_range(15))});
                  n += 1;
               end else begin
                  pkt_q.push_back({level_id, 4'($urandom_range(1, 15))});
                  n += 1;
               end
            end
         end
         repeat ($urandom_range(6)) pkt_q.push_back(8'($urandom_range(255)));
         if ($urandom_range(9) == 0) begin
            n = $urandom_range(1, pkt_q.size() - 1);
            while (pkt_q.size() > n) void'(pkt_q.pop_back());
         end
      end
   endfunction

   // ---------------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------------

   // Reset value reads back, then write ID 14 and return to the default.
   task automatic test_level_id_register();
      logic [rtpal_pkg::CSR_DATA_W-1:0] rd;
      csr_access(1'b0, '0, rd);
      if (rd !== {{(rtpal_pkg::CSR_DATA_W - 4){1'b0}}, rtpal_pkg::LEVEL_ID_RST})
         report_mismatch($sformatf("level_ext_id after reset: got %0h", rd));
      set_level_id(4'd14);
      set_level_id(rtpal_pkg::LEVEL_ID_RST);
   endtask

   // Minimum sizes, short headers, the full CSRC list and an empty extension.
   task automatic test_header_lengths();
      begin_packet(4'd0, 1'b0);
      send_packet();
      begin_packet(4'd0, 1'b0);
      void'(pkt_q.pop_back());
      send_packet();
      pkt_q.delete();
      pkt_q.push_back(8'hFF);
      send_packet();
      begin_packet(4'd15, 1'b0);
      push_word(32'h1000_00FF);
      send_packet();
      begin_ext_packet(4'd15, rtpal_pkg::BEDE_PROFILE, 16'd0);
      send_packet();
   endtask

   // Voice bit dropped, last match wins, padding skipped, other elements stepped over.
   task automatic test_level_extraction();
      begin_ext_packet(4'd0, rtpal_pkg::BEDE_PROFILE, 16'd1);
      push_word(32'h10D5_0000);
      send_packet();
      begin_ext_packet(4'd0, rtpal_pkg::BEDE_PROFILE, 16'd2);
      push_word(32'h1000_0010);
      push_word(32'hFF00_0000);
      send_packet();
      begin_ext_packet(4'd2, rtpal_pkg::BEDE_PROFILE, 16'd1);
      push_word(32'h0000_1080);
      send_packet();
      begin_ext_packet(4'd0, rtpal_pkg::BEDE_PROFILE, 16'd2);
      push_word(32'h23AA_BBCC);
      push_word(32'hDD10_6600);
      send_packet();
   endtask

   // Stop ID, overrun, bad length on a match, and level elements outside the area.
   task automatic test_walk_termination();
      begin_ext_packet(4'd0, rtpal_pkg::BEDE_PROFILE, 16'd2);
      push_word(32'h1011_F010);
      push_word(32'h4400_0000);
      send_packet();
      begin_ext_packet(4'd0, rtpal_pkg::BEDE_PROFILE, 16'd1);
      push_word(32'h1005_2399);
      send_packet();
      begin_ext_packet(4'd0, rtpal_pkg::BEDE_PROFILE, 16'd2);
      push_word(32'h1009_11AA);
      push_word(32'hBB10_2200);
      send_packet();
      begin_ext_packet(4'd1, rtpal_pkg::BEDE_PROFILE, 16'd0);
      push_word(32'h1033_0000);
      send_packet();
      // element data ends exactly on the area boundary
      begin_ext_packet(4'd0, rtpal_pkg::BEDE_PROFILE, 16'd1);
      push_word(32'h3201_0203);
      push_word(32'h1044_0000);
      send_packet();
   endtask

   // No walk without the profile or the X bit; only the length counts.
   task automatic test_foreign_profile();
      begin_ext_packet(4'd0, 16'h1000, 16'd1);
      push_word(32'h105A_0000);
      send_packet();
      begin_packet(4'd0, 1'b0);
      push_word({rtpal_pkg::BEDE_PROFILE, 16'd1});
      push_word(32'h105A_0000);
      send_packet();
      begin_ext_packet(4'd1, rtpal_pkg::BEDE_PROFILE ^ 16'h0001, 16'd0);
      send_packet();
   endtask

   // A truncated extension must leave the stored level alone.
   task automatic test_short_packet_keeps_level();
      begin_ext_packet(4'd0, rtpal_pkg::BEDE_PROFILE, 16'd2);
      push_word(32'h103C_0000);
      void'(pkt_q.pop_back());
      void'(pkt_q.pop_back());
      send_packet();
      begin_ext_packet(4'd1, rtpal_pkg::BEDE_PROFILE, 16'h0100);
      push_word(32'h103C_0000);
      send_packet();
   endtask

   // IDs 0 and 15 collide with padding and stop, so they never match.
   task automatic test_unmatchable_ids();
      set_level_id(rtpal_pkg::PAD_ID);
      begin_ext_packet(4'd0, rtpal_pkg::BEDE_PROFILE, 16'd1);
      push_word(32'h000F_1012);
      send_packet();
      set_level_id(rtpal_pkg::STOP_ID);
      begin_ext_packet(4'd0, rtpal_pkg::BEDE_PROFILE, 16'd1);
      push_word(32'hF07E_0000);
      send_packet();
      set_level_id(rtpal_pkg::LEVEL_ID_RST);
   endtask

   // Long padding run with the level element in the last two area bytes, one past the end.
   task automatic test_long_extension();
      begin_ext_packet(4'd0, rtpal_pkg::BEDE_PROFILE, 16'd10);
      repeat (38) pkt_q.push_back(8'h00);
      pkt_q.push_back({level_id, 4'h0});
      pkt_q.push_back(8'h2A);
      push_word(32'h1055_0000);
      send_packet();
      wait_for_results();
   endtask

   // Block the receiver long enough to back the DUT up, then drain fully.
   task automatic test_receiver_holdoff();
      rx_hold_request = 400;
      repeat (12) begin
         begin_packet(4'd0, 1'b0);
         repeat ($urandom_range(3)) pkt_q.push_back(8'($urandom_range(255)));
         send_packet();
      end
      wait_for_results();
   endtask

   task automatic test_random_packets(input int byte_goal, input int packet_goal);
      int bytes_done;
      int pkts_done;
      bytes_done = 0;
      pkts_done  = 0;
      while (bytes_done < byte_goal || pkts_done < packet_goal) begin
         build_random_packet();
         bytes_done += pkt_q.size();
         pkts_done++;
         send_packet();
      end
   endtask

   // ---------------------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------------------

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Sender sparse-ish, receiver stalls about half the time.
      tx_idle_pct = 36;
      rx_idle_pct = 49;
      test_level_id_register();
      test_header_lengths();
      test_level_extraction();
      test_walk_termination();
      test_foreign_profile();
      test_short_packet_keeps_level();
      test_unmatchable_ids();
      test_random_packets(40, 1);
      set_level_id(4'd14);
      test_random_packets(40, 1);

      // Swap the idle rates.
      tx_idle_pct = 49;
      rx_idle_pct = 36;
      test_receiver_holdoff();
      set_level_id(rtpal_pkg::PAD_ID);
      test_random_packets(20, 1);
      set_level_id(rtpal_pkg::STOP_ID);
      test_random_packets(20, 1);
      set_level_id(4'd7);
      test_random_packets(40, 1);

      // Back to back on both sides.
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      set_level_id(rtpal_pkg::LEVEL_ID_RST);
      test_long_extension();
      set_level_id(4'($urandom_range(2, 13)));
      test_random_packets(40, 1);
      set_level_id(rtpal_pkg::LEVEL_ID_RST);
      test_random_packets(20, 1);

      wait_for_results();
      repeat (2 * SETTLE_CYCLES) @(posedge clock);

      $display("Covered %0d packets (%0d bytes) under three idle mixes and several level IDs.",
               packets_sent, bytes_accepted);
      $display("Checked %0d results: %0d carried a new level, %0d were flagged short.",
               results_seen, updates_seen, shorts_seen);
      if (error_count == 0) begin
         $display("tb_rtp_audio_level_extension_parser: done, clean");
      end else begin
         $display("tb_rtp_audio_level_extension_parser: done, errors");
      end
      $finish;
   end

   // Watchdog: a hang anywhere ends the run as a failure.
   initial begin
      #(RUN_LIMIT_NS);
      $display("TIMEOUT with %0d results still owed", level_reports_q.size());
      $display("tb_rtp_audio_level_extension_parser: done, errors");
      $finish;
   end

endmodule
